// ===== hw/rtl/srg_pkg.sv =====
package srg_pkg;

  // Command codes carried by an input request.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // Result kinds.
  localparam logic EVT_STEP   = 1'b0;
  localparam logic EVT_PERIOD = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAMP_START = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAMP_END   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_SIZE  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICK_DELAY = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_MODE  = 3'd4;

  // Reset values, cut down to the configured widths where they are used.
  localparam logic [63:0] RAMP_START_RST = 64'd0;
  localparam logic [63:0] RAMP_END_RST   = 64'd229376;  // 3.5 in Q16.16
  localparam logic [63:0] STEP_SIZE_RST  = 64'd6554;    // about 0.1 in Q16.16
  localparam logic [63:0] TICK_DELAY_RST = 64'd250;
  localparam logic        STEP_MODE_RST  = 1'b0;

  // One input request as held in the input register.
  typedef struct packed {
    logic [1:0] cmd;
    logic       trigger_level;
  } item_t;

endpackage

// ===== hw/rtl/srg_in_if.sv =====
interface srg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       trigger_level;

  modport source (output valid, output cmd, output trigger_level, input ready);
  modport sink   (input valid, input cmd, input trigger_level, output ready);
endinterface

// ===== hw/rtl/srg_out_if.sv =====
interface srg_out_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] ramp_value;
  logic                          event_kind;

  modport source (output valid, output ramp_value, output event_kind, input ready);
  modport sink   (input valid, input ramp_value, input event_kind, output ready);
endinterface

// ===== hw/rtl/srg_cfg_if.sv =====
interface srg_cfg_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            index;
  logic [DATA_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/srg_cfg.sv =====
module srg_cfg
  import srg_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned DELAY_WIDTH = 24,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  srg_cfg_if.sink                cfg,
  output logic [VALUE_WIDTH-1:0] ramp_start,
  output logic [VALUE_WIDTH-1:0] ramp_end,
  output logic [VALUE_WIDTH-1:0] step_size,
  output logic [DELAY_WIDTH-1:0] tick_delay,
  output logic                   step_mode
);

  // Writes are always taken at once.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_start <= RAMP_START_RST[VALUE_WIDTH-1:0];
      ramp_end   <= RAMP_END_RST[VALUE_WIDTH-1:0];
      step_size  <= STEP_SIZE_RST[VALUE_WIDTH-1:0];
      tick_delay <= TICK_DELAY_RST[DELAY_WIDTH-1:0];
      step_mode  <= STEP_MODE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RAMP_START: ramp_start <= cfg.data[VALUE_WIDTH-1:0];
        REG_RAMP_END:   ramp_end   <= cfg.data[VALUE_WIDTH-1:0];
        REG_STEP_SIZE:  step_size  <= cfg.data[VALUE_WIDTH-1:0];
        REG_TICK_DELAY: tick_delay <= cfg.data[DELAY_WIDTH-1:0];
        REG_STEP_MODE:  step_mode  <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/srg_step.sv =====
module srg_step
  import srg_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned DELAY_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  item_t                  item,
  input  logic                   advance,
  input  logic [VALUE_WIDTH-1:0] ramp_start,
  input  logic [VALUE_WIDTH-1:0] ramp_end,
  input  logic [VALUE_WIDTH-1:0] step_size,
  input  logic [DELAY_WIDTH-1:0] tick_delay,
  input  logic                   step_mode,
  output logic                   res_valid,
  output logic [VALUE_WIDTH-1:0] res_value,
  output logic                   res_kind
);

  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [VALUE_WIDTH-1:0] current_value, current_value_next;
  logic                   timer_running, timer_running_next;
  logic [DELAY_WIDTH-1:0] delay_count, delay_count_next;

  logic [VALUE_WIDTH-1:0] base_value;
  logic                   descending;
  logic                   passed_end;
  logic                   step_pos;
  logic [VALUE_WIDTH-1:0] eff_step;
  logic [VALUE_WIDTH:0]   sum;
  logic [VALUE_WIDTH-1:0] sat_sum;
  logic                   do_fire;

  // A start request reloads the value before any step that it fires.
  assign base_value = (item.cmd == CMD_START) ? ramp_start : current_value;
  assign descending = $signed(ramp_end) < $signed(ramp_start);
  assign passed_end = descending ? ($signed(base_value) < $signed(ramp_end))
                                 : ($signed(ramp_end) < $signed(base_value));
  assign step_pos   = !step_size[VALUE_WIDTH-1] && (|step_size);
  assign eff_step   = (descending && step_pos) ? (~step_size + VALUE_WIDTH'(1)) : step_size;
  assign sum        = {base_value[VALUE_WIDTH-1], base_value}
                    + {eff_step[VALUE_WIDTH-1], eff_step};
  assign sat_sum    = (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1])
                    ? (sum[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX)
                    : sum[VALUE_WIDTH-1:0];

  always_comb begin
    current_value_next = current_value;
    timer_running_next = timer_running;
    delay_count_next   = delay_count;
    do_fire            = 1'b0;
    case (item.cmd)
      CMD_TICK: begin
        if (timer_running) begin
          if (delay_count <= DELAY_WIDTH'(1)) begin
            delay_count_next = tick_delay;
            do_fire          = 1'b1;
          end else begin
            delay_count_next = delay_count - DELAY_WIDTH'(1);
          end
        end
      end
      CMD_START: begin
        current_value_next = ramp_start;
        if (item.trigger_level) begin
          if (step_mode) begin
            do_fire = 1'b1;
          end else begin
            timer_running_next = 1'b1;
            delay_count_next   = tick_delay;
          end
        end
      end
      CMD_STEP: begin
        do_fire = item.trigger_level && step_mode;
      end
      default: begin
      end
    endcase

    res_valid = do_fire;
    res_value = '0;
    res_kind  = EVT_STEP;
    if (do_fire) begin
      if (passed_end) begin
        timer_running_next = 1'b0;
        res_kind           = EVT_PERIOD;
      end else begin
        res_value          = base_value;
        current_value_next = sat_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_value <= '0;
      timer_running <= 1'b0;
      delay_count   <= '0;
    end else if (advance) begin
      current_value <= current_value_next;
      timer_running <= timer_running_next;
      delay_count   <= delay_count_next;
    end
  end

  // A finished period always stops the timer.
  assert property (@(posedge clk) disable iff (rst)
    advance && res_valid && (res_kind == EVT_PERIOD) |=> !timer_running)
    else $error("timer still running after period end");

  // A low start trigger only reloads the value.
  assert property (@(posedge clk) disable iff (rst)
    advance && (item.cmd == CMD_START) && !item.trigger_level
      |=> current_value == $past(ramp_start))
    else $error("start trigger did not reload the ramp value");

  // An idle timer never fires on a tick.
  assert property (@(posedge clk) disable iff (rst)
    (item.cmd == CMD_TICK) && !timer_running |-> !res_valid)
    else $error("tick fired with the timer stopped");

endmodule

// ===== hw/rtl/stepped_ramp_generator.sv =====
// Staircase ramp source, signed Q16.16 values.
// Requests arrive on the items channel: a tick of the step timer, a start
// trigger or a step trigger, each with its trigger level. Results leave on
// the results channel as a ramp value with a step-done mark, or a
// period-done mark once the value has passed the end value. A request gives
// at most one result. The configuration channel writes the start value, end
// value, step width, step delay and step mode; it is always ready. The user
// must write it only while no request is in flight; the block itself does not enforce this.
// A request is registered in the input register when taken and worked from
// there by the ramp core, which loads its result into the output register.
// One request is taken per cycle while the output register is free or the
// held request gives no result.
// When the receiver stalls the result waits in the output register; a held
// request that gives no result still moves on, one that gives a result waits
// until the output register is free, and the input stalls behind it.
// Reset restores the configuration defaults, zeroes the ramp value, stops
// the timer and empties both registers.
module stepped_ramp_generator
  import srg_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned DELAY_WIDTH = 24
) (
  input logic      clk,
  input logic      rst,
  srg_in_if.sink   items,
  srg_out_if.source results,
  srg_cfg_if.sink  cfg
);

  localparam int unsigned DATA_WIDTH = (VALUE_WIDTH > DELAY_WIDTH) ? VALUE_WIDTH : DELAY_WIDTH;

  // Configuration registers.
  logic [VALUE_WIDTH-1:0] ramp_start;
  logic [VALUE_WIDTH-1:0] ramp_end;
  logic [VALUE_WIDTH-1:0] step_size;
  logic [DELAY_WIDTH-1:0] tick_delay;
  logic                   step_mode;

  srg_cfg #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DELAY_WIDTH (DELAY_WIDTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .ramp_start (ramp_start),
    .ramp_end   (ramp_end),
    .step_size  (step_size),
    .tick_delay (tick_delay),
    .step_mode  (step_mode)
  );

  // Input register: holds one request until the core has worked it.
  item_t item;
  logic  item_valid;

  // Output register.
  logic                   out_valid;
  logic [VALUE_WIDTH-1:0] out_value;
  logic                   out_kind;

  logic                   res_valid;
  logic [VALUE_WIDTH-1:0] res_value;
  logic                   res_kind;
  logic                   out_free;
  logic                   advance;

  assign out_free    = !out_valid || results.ready;
  // A request with no result need not wait for the output register.
  assign advance     = item_valid && (out_free || !res_valid);
  assign items.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items.ready) begin
      item_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      item.cmd           <= items.cmd;
      item.trigger_level <= items.trigger_level;
    end
  end

  srg_step #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .advance    (advance),
    .ramp_start (ramp_start),
    .ramp_end   (ramp_end),
    .step_size  (step_size),
    .tick_delay (tick_delay),
    .step_mode  (step_mode),
    .res_valid  (res_valid),
    .res_value  (res_value),
    .res_kind   (res_kind)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_value <= res_value;
      out_kind  <= res_kind;
    end
  end

  assign results.valid      = out_valid;
  assign results.ramp_value = out_value;
  assign results.event_kind = out_kind;

  // A period-done result carries a zero value.
  assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.event_kind == EVT_PERIOD) |-> results.ramp_value == '0)
    else $error("period-done result with a non-zero value");

  // A result is only ever loaded by a request that the core has worked.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && res_valid))
    else $error("result appeared without a worked request");

  // The core never overwrites a result that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    advance && res_valid |-> out_free)
    else $error("waiting result overwritten");

endmodule
